### rtl/shg_pkg.sv
// ----------------------------------------------------------------------------
// shg_pkg
// Types, constants and helpers shared by the scrambled Halton generator.
// ----------------------------------------------------------------------------
package shg_pkg;

    localparam int MAX_DIMS_DEF      = 8;
    localparam int MAX_DIGITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 32;
    localparam int GUARD_BITS_DEF    = 8;

    localparam int OP_W    = 2;
    localparam int DIM_W   = 3;
    localparam int SLOT_W  = 5;
    localparam int FRAC_W  = 32;
    localparam int CFG_W   = 4;
    localparam int DIV_RAD = 4;   // quotient bits per divider cycle

    localparam logic [OP_W-1:0] OP_DRAW    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    typedef struct packed {
        logic load;
        logic restart;
        logic start_draw;
        logic rd_digit;
        logic adv_clr;
        logic adv_inc;
        logic grow;
        logic ovf;
        logic ri_init;
        logic ri_rd;
        logic perm_rd;
        logic div_load;
        logic div_step;
        logic next_dim;
    } t_cmd;

    typedef struct packed {
        logic idx_lt_cnt;
        logic cnt_full;
        logic digit_max;
        logic idx_zero;
        logic div_last;
        logic last_dim;
    } t_sts;

    function automatic logic [SLOT_W-1:0] prime_of(input logic [DIM_W-1:0] d);
        logic [SLOT_W-1:0] p;
        case (d)
            3'd0:    p = 5'd2;
            3'd1:    p = 5'd3;
            3'd2:    p = 5'd5;
            3'd3:    p = 5'd7;
            3'd4:    p = 5'd11;
            3'd5:    p = 5'd13;
            3'd6:    p = 5'd17;
            default: p = 5'd19;
        endcase
        return p;
    endfunction

endpackage

### rtl/shg_in_if.sv
// ----------------------------------------------------------------------------
// shg_in_if
// Request channel: operation and permutation load fields.
// ----------------------------------------------------------------------------
interface shg_in_if
    import shg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [DIM_W-1:0]  dimension;
    logic [SLOT_W-1:0] entry_index;
    logic [SLOT_W-1:0] entry_value;

    modport source (output valid, operation, dimension, entry_index, entry_value,
                    input ready);
    modport sink   (input valid, operation, dimension, entry_index, entry_value,
                    output ready);
endinterface

### rtl/shg_out_if.sv
// ----------------------------------------------------------------------------
// shg_out_if
// Result channel: one coordinate per transfer.
// ----------------------------------------------------------------------------
interface shg_out_if
    import shg_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIM_W-1:0]  out_dimension;
    logic [FRAC_W-1:0] fraction;
    logic              last_of_point;
    logic              wrapped;

    modport source (output valid, out_dimension, fraction, last_of_point, wrapped,
                    input ready);
    modport sink   (input valid, out_dimension, fraction, last_of_point, wrapped,
                    output ready);
endinterface

### rtl/shg_ctrl.sv
// ----------------------------------------------------------------------------
// shg_ctrl
// Sequencer: counter increment, Horner walk and result handshake.
// ----------------------------------------------------------------------------
module shg_ctrl
    import shg_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_operation,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  t_sts            i_sts,
    output t_cmd            o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_ADV_RD  = 9'b000000010,
        S_ADV_CHK = 9'b000000100,
        S_RI_INIT = 9'b000001000,
        S_RI_RD   = 9'b000010000,
        S_RI_PERM = 9'b000100000,
        S_RI_LOAD = 9'b001000000,
        S_RI_DIV  = 9'b010000000,
        S_OUT     = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_operation)
                        OP_DRAW: begin
                            o_cmd.start_draw = 1'b1;
                            n_state          = S_ADV_RD;
                        end
                        OP_LOAD:    o_cmd.load    = 1'b1;
                        OP_RESTART: o_cmd.restart = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_ADV_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd.rd_digit = 1'b1;
                    n_state        = S_ADV_CHK;
                end else if (!i_sts.cnt_full) begin
                    o_cmd.grow = 1'b1;
                    n_state    = S_RI_INIT;
                end else begin
                    o_cmd.ovf = 1'b1;
                    n_state   = S_OUT;
                end
            end
            S_ADV_CHK: begin
                // propagate carry while the digit sits at base-1
                if (i_sts.digit_max) begin
                    o_cmd.adv_clr = 1'b1;
                    n_state       = S_ADV_RD;
                end else begin
                    o_cmd.adv_inc = 1'b1;
                    n_state       = S_RI_INIT;
                end
            end
            S_RI_INIT: begin
                o_cmd.ri_init = 1'b1;
                n_state       = S_RI_RD;
            end
            S_RI_RD: begin
                if (i_sts.idx_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.ri_rd = 1'b1;
                    n_state     = S_RI_PERM;
                end
            end
            S_RI_PERM: begin
                o_cmd.perm_rd = 1'b1;
                n_state       = S_RI_LOAD;
            end
            S_RI_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_RI_DIV;
            end
            S_RI_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RI_RD;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last_dim) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_dim = 1'b1;
                        n_state        = S_ADV_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/shg_datapath.sv
// ----------------------------------------------------------------------------
// shg_datapath
// Digit counters, permutation tables, radix-16 divider and result registers.
// ----------------------------------------------------------------------------
module shg_datapath
    import shg_pkg::*;
#(
    parameter int MAX_DIMS      = MAX_DIMS_DEF,
    parameter int MAX_DIGITS    = MAX_DIGITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int GUARD_BITS    = GUARD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic [DIM_W-1:0]  i_dimension,
    input  logic [SLOT_W-1:0] i_entry_index,
    input  logic [SLOT_W-1:0] i_entry_value,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [DIM_W-1:0]  o_out_dimension,
    output logic [FRAC_W-1:0] o_fraction,
    output logic              o_last_of_point,
    output logic              o_wrapped
);

    localparam int PREC_RAW  = FRACTION_BITS + GUARD_BITS;
    localparam int PREC      = (PREC_RAW > 58) ? 58 : PREC_RAW;
    localparam int OUT_SHIFT = (PREC > FRACTION_BITS) ? PREC - FRACTION_BITS : 0;
    localparam int DW        = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DIG_AW    = $clog2(MAX_DIGITS);
    localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int DVD_W     = PREC + SLOT_W;
    localparam int DIV_CYC   = (DVD_W + DIV_RAD - 1) / DIV_RAD;
    localparam int DIV_PW    = DIV_CYC * DIV_RAD;
    localparam int DIVC_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int PA_W      = DW + SLOT_W;
    localparam int DA_W      = DW + DIG_AW;

    logic [CFG_W-1:0]  r_dims;
    logic [DW-1:0]     r_d;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_cnt [MAX_DIMS];
    logic [PREC-1:0]   r_f;
    logic              r_wrap;
    logic [DIV_PW-1:0] r_q;
    logic [SLOT_W-1:0] r_rem;
    logic [DIVC_W-1:0] r_divc;

    logic [SLOT_W-1:0] dig_mem [2**DA_W];
    logic [SLOT_W-1:0] r_dig_rd;
    logic [SLOT_W-1:0] perm_mem [2**PA_W];
    logic              r_perm_vld [2**PA_W];
    logic [SLOT_W-1:0] r_perm_rd;
    logic              r_perm_hit;
    logic [SLOT_W-1:0] r_perm_slot;

    logic [CNT_W-1:0]  cur_cnt;
    logic [SLOT_W-1:0] base;
    logic [CFG_W-1:0]  n_act;
    logic [CNT_W-1:0]  idx_m1;
    logic [SLOT_W-1:0] perm_val;
    logic              load_ok;
    logic [PA_W-1:0]   load_addr;
    logic [PA_W-1:0]   perm_addr;
    logic              dig_we;
    logic [DA_W-1:0]   dig_waddr;
    logic [SLOT_W-1:0] dig_wdata;
    logic              dig_re;
    logic [DA_W-1:0]   dig_raddr;
    logic [DIV_PW-1:0] n_q;
    logic [SLOT_W-1:0] n_rem;
    logic [SLOT_W:0]   trial;
    logic [PREC+FRAC_W-1:0] f_ext;

    assign cur_cnt  = r_cnt[r_d];
    assign base     = prime_of(DIM_W'(r_d));
    assign idx_m1   = r_idx - CNT_W'(1);
    assign perm_val = r_perm_hit ? r_perm_rd : r_perm_slot;

    always_comb begin
        if (r_dims == '0) begin
            n_act = CFG_W'(1);
        end else if (r_dims > CFG_W'(MAX_DIMS)) begin
            n_act = CFG_W'(MAX_DIMS);
        end else begin
            n_act = r_dims;
        end
    end

    assign load_ok = ({1'b0, i_dimension} < (DIM_W+1)'(MAX_DIMS))
                   && (i_entry_index < prime_of(i_dimension))
                   && (i_entry_value < prime_of(i_dimension));
    assign load_addr = {i_dimension[DW-1:0], i_entry_index};
    assign perm_addr = {r_d, r_dig_rd};

    always_comb begin
        dig_we    = 1'b0;
        dig_waddr = {r_d, r_idx[DIG_AW-1:0]};
        dig_wdata = '0;
        if (i_cmd.adv_clr) begin
            dig_we = 1'b1;
        end else if (i_cmd.adv_inc) begin
            dig_we    = 1'b1;
            dig_wdata = r_dig_rd + SLOT_W'(1);
        end else if (i_cmd.grow) begin
            dig_we    = 1'b1;
            dig_waddr = {r_d, cur_cnt[DIG_AW-1:0]};
            dig_wdata = SLOT_W'(1);
        end
        dig_re    = i_cmd.rd_digit | i_cmd.ri_rd;
        dig_raddr = i_cmd.ri_rd ? {r_d, idx_m1[DIG_AW-1:0]} : {r_d, r_idx[DIG_AW-1:0]};
    end

    // one restoring step per quotient bit, DIV_RAD bits a cycle
    always_comb begin
        n_q   = r_q;
        n_rem = r_rem;
        trial = '0;
        for (int j = 0; j < DIV_RAD; j++) begin
            trial = {n_rem, n_q[DIV_PW-1]};
            n_q   = {n_q[DIV_PW-2:0], 1'b0};
            if (trial >= {1'b0, base}) begin
                n_rem  = SLOT_W'(trial - {1'b0, base});
                n_q[0] = 1'b1;
            end else begin
                n_rem = trial[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            dig_mem[dig_waddr] <= dig_wdata;
        end
        if (dig_re) begin
            r_dig_rd <= dig_mem[dig_raddr];
        end
        if (i_cmd.load && load_ok) begin
            perm_mem[load_addr] <= i_entry_value;
        end
        if (i_cmd.perm_rd) begin
            r_perm_rd   <= perm_mem[perm_addr];
            r_perm_hit  <= r_perm_vld[perm_addr];
            r_perm_slot <= r_dig_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 2**PA_W; a++) begin
                r_perm_vld[a] <= 1'b0;
            end
        end else if (i_cmd.load && load_ok) begin
            r_perm_vld[load_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= CFG_W'(1);
            r_d    <= '0;
            r_idx  <= '0;
            r_wrap <= 1'b0;
            r_divc <= '0;
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_dims <= i_cfg_wdata;
            end
            if (i_cmd.restart) begin
                for (int k = 0; k < MAX_DIMS; k++) begin
                    r_cnt[k] <= '0;
                end
            end
            if (i_cmd.start_draw) begin
                r_d    <= '0;
                r_idx  <= '0;
                r_wrap <= 1'b0;
            end
            if (i_cmd.next_dim) begin
                r_d    <= r_d + DW'(1);
                r_idx  <= '0;
                r_wrap <= 1'b0;
            end
            if (i_cmd.adv_clr) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.grow) begin
                r_cnt[r_d] <= cur_cnt + CNT_W'(1);
            end
            if (i_cmd.ovf) begin
                r_cnt[r_d] <= '0;
                r_wrap     <= 1'b1;
            end
            if (i_cmd.ri_init) begin
                r_idx <= cur_cnt;
            end
            if (i_cmd.ri_rd) begin
                r_idx <= idx_m1;
            end
            if (i_cmd.div_load) begin
                r_divc <= '0;
            end
            if (i_cmd.div_step) begin
                r_divc <= r_divc + DIVC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ovf || i_cmd.ri_init) begin
            r_f <= '0;
        end
        if (i_cmd.div_load) begin
            r_q   <= DIV_PW'({perm_val, r_f});
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            if (o_sts.div_last) begin
                r_f <= n_q[PREC-1:0];
            end
        end
    end

    assign o_sts.idx_lt_cnt = (r_idx < cur_cnt);
    assign o_sts.cnt_full   = (cur_cnt == CNT_W'(MAX_DIGITS));
    assign o_sts.digit_max  = (r_dig_rd == base - SLOT_W'(1));
    assign o_sts.idx_zero   = (r_idx == '0);
    assign o_sts.div_last   = (r_divc == DIVC_W'(DIV_CYC - 1));
    assign o_sts.last_dim   = ((CFG_W'(r_d) + CFG_W'(1)) == n_act);

    assign f_ext           = {{FRAC_W{1'b0}}, r_f} >> OUT_SHIFT;
    assign o_fraction      = f_ext[FRAC_W-1:0];
    assign o_out_dimension = DIM_W'(r_d);
    assign o_last_of_point = o_sts.last_dim;
    assign o_wrapped       = r_wrap;

endmodule

### rtl/scrambled_halton_generator_top.sv
// ----------------------------------------------------------------------------
// scrambled_halton_generator_top
// Generalized Halton point generator with loadable digit permutations.
//
//  channel   dir  handshake      contents
//  i_req     in   valid/ready    operation, dimension, entry_index, entry_value
//  o_rsp     out  valid/ready    out_dimension, fraction, last_of_point, wrapped
//  i_cfg_*   in   write enable   dims_in_use
//
// Load, restart and unused operations complete in the idle state. A draw, per
// dimension, clears each carried digit, then increments the first digit below
// base-1 or appends a new digit of one, then runs the n-digit Horner walk (read,
// permute, load, divide per digit) on the shared radix-16 divider; the result
// then waits in its register until taken. An overflowed counter skips the walk
// and shows its result the cycle after. Reset is synchronous; tables need no
// sweep after it. A stalled result blocks the next request.
// ----------------------------------------------------------------------------
module scrambled_halton_generator_top
    import shg_pkg::*;
#(
    parameter int MAX_DIMS      = MAX_DIMS_DEF,
    parameter int MAX_DIGITS    = MAX_DIGITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int GUARD_BITS    = GUARD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    shg_in_if.sink           i_req,
    shg_out_if.source        o_rsp
);

    t_cmd cmd;
    t_sts sts;

    shg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_operation (i_req.operation),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    shg_datapath #(
        .MAX_DIMS      (MAX_DIMS),
        .MAX_DIGITS    (MAX_DIGITS),
        .FRACTION_BITS (FRACTION_BITS),
        .GUARD_BITS    (GUARD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_dimension     (i_req.dimension),
        .i_entry_index   (i_req.entry_index),
        .i_entry_value   (i_req.entry_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_dimension (o_rsp.out_dimension),
        .o_fraction      (o_rsp.fraction),
        .o_last_of_point (o_rsp.last_of_point),
        .o_wrapped       (o_rsp.wrapped)
    );

endmodule

### rtl/shg_checker.sv
// ----------------------------------------------------------------------------
// shg_checker
// Port-level checks on the generator's request and result sequencing.
// ----------------------------------------------------------------------------
module shg_checker
    import shg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [OP_W-1:0]   i_operation,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [FRAC_W-1:0] i_fraction,
    input logic              i_wrapped
);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("request taken while a result is pending");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_operation == OP_DRAW) |=> !i_in_ready)
        else $error("draw did not hold off the next request");

    a_gap_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> !i_out_valid)
        else $error("back-to-back results without recomputation");

    a_wrap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_wrapped) |-> (i_fraction == '0))
        else $error("wrapped coordinate with nonzero fraction");

endmodule

bind scrambled_halton_generator_top shg_checker u_shg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_operation (i_req.operation),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_fraction  (o_rsp.fraction),
    .i_wrapped   (o_rsp.wrapped)
);
